[rtl/static_knee_compressor_assert.svh]
// Assertion macros shared by the compressor RTL
`ifndef STATIC_KNEE_COMPRESSOR_ASSERT_SVH
`define STATIC_KNEE_COMPRESSOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: %m");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: %m");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

[rtl/skc_pkg.sv]
package skc_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF   = 14;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [CSR_ADDR_BITS-3:0] {
      REG_KNEE   = 2'd0,
      REG_TARGET = 2'd1,
      REG_MAX    = 2'd2,
      REG_BYPASS = 2'd3
   } reg_index_type;

endpackage

[rtl/skc_div_cell.sv]
// One restoring-division step: shifts the next dividend bit into the
// partial remainder and shifts the quotient bit into the low end.
module skc_div_cell #(
   parameter int DIV_BITS  = 15,
   parameter int ACC_BITS  = 16,
   parameter int SIDE_BITS = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [DIV_BITS-1:0]  divisor,
   input  logic                 in_valid,
   input  logic [DIV_BITS-1:0]  in_rem,
   input  logic [ACC_BITS-1:0]  in_acc,
   input  logic [SIDE_BITS-1:0] in_side,
   output logic                 out_valid,
   output logic [DIV_BITS-1:0]  out_rem,
   output logic [ACC_BITS-1:0]  out_acc,
   output logic [SIDE_BITS-1:0] out_side
);

   logic [DIV_BITS:0]    trial;
   logic [DIV_BITS:0]    diff;
   logic                 ge;
   logic [DIV_BITS-1:0]  rem_in;
   logic [ACC_BITS-1:0]  acc_in;
   logic                 valid_ff;
   logic [DIV_BITS-1:0]  rem_ff;
   logic [ACC_BITS-1:0]  acc_ff;
   logic [SIDE_BITS-1:0] side_ff;

   assign trial  = {in_rem, in_acc[ACC_BITS-1]};
   assign ge     = trial >= {1'b0, divisor};
   assign diff   = trial - {1'b0, divisor};
   assign rem_in = ge ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
   assign acc_in = {in_acc[ACC_BITS-2:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in;
         acc_ff  <= acc_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_acc   = acc_ff;
   assign out_side  = side_ff;

endmodule

[rtl/skc_div_chain.sv]
// Row of division cells, one quotient bit per cell. The partial remainder
// entering the row must be below the divisor.
module skc_div_chain #(
   parameter int DIV_BITS  = 15,
   parameter int ACC_BITS  = 16,
   parameter int SIDE_BITS = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [DIV_BITS-1:0]  divisor,
   input  logic                 in_valid,
   input  logic [DIV_BITS-1:0]  in_rem,
   input  logic [ACC_BITS-1:0]  in_acc,
   input  logic [SIDE_BITS-1:0] in_side,
   output logic                 out_valid,
   output logic [ACC_BITS-1:0]  out_quot,
   output logic [SIDE_BITS-1:0] out_side
);

   logic                 valid_w [0:ACC_BITS];
   logic [DIV_BITS-1:0]  rem_w   [0:ACC_BITS];
   logic [ACC_BITS-1:0]  acc_w   [0:ACC_BITS];
   logic [SIDE_BITS-1:0] side_w  [0:ACC_BITS];

   assign valid_w[0] = in_valid;
   assign rem_w[0]   = in_rem;
   assign acc_w[0]   = in_acc;
   assign side_w[0]  = in_side;

   for (genvar i = 0; i < ACC_BITS; i++) begin : g_cell
      skc_div_cell #(
         .DIV_BITS  (DIV_BITS),
         .ACC_BITS  (ACC_BITS),
         .SIDE_BITS (SIDE_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .divisor   (divisor),
         .in_valid  (valid_w[i]),
         .in_rem    (rem_w[i]),
         .in_acc    (acc_w[i]),
         .in_side   (side_w[i]),
         .out_valid (valid_w[i+1]),
         .out_rem   (rem_w[i+1]),
         .out_acc   (acc_w[i+1]),
         .out_side  (side_w[i+1])
      );
   end

   assign out_valid = valid_w[ACC_BITS];
   assign out_quot  = acc_w[ACC_BITS];
   assign out_side  = side_w[ACC_BITS];

endmodule

[rtl/static_knee_compressor.sv]
// Channel    Direction  Handshake            Payload
// req_       in         req_valid/req_stall  req_sample_in
// rsp_       out        rsp_valid/rsp_stall  rsp_sample_out, rsp_clipped
// csr_       in         APB write/read       knee, target, max, bypass at 4*i
//
// One transaction per cycle sustained while req_stall is low; the two division
// rows produce one quotient bit per cell.
// Reset clears all valid bits and loads the register reset values.
// A held result is kept in the output register and one more in a skid
// register; req_stall is high only while the skid register is full, and
// then the whole pipeline holds.
`include "static_knee_compressor_assert.svh"

module static_knee_compressor #(
   parameter int SAMPLE_BITS = skc_pkg::SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = skc_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]       rsp_sample_out,
   output logic                                rsp_clipped,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [skc_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [skc_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [skc_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready
);

   localparam int W  = SAMPLE_BITS;
   localparam int LW = W - 1;          // level register width
   localparam int NW = 2 * W - 1;      // first dividend / quotient width
   localparam int PW = NW + LW;        // second dividend width
   localparam int DW = skc_pkg::CSR_DATA_BITS;

   localparam logic [LW-1:0] UNITY = LW'(64'd1 << FRAC_BITS);
   localparam logic [W-1:0]  SMAX  = {1'b0, {LW{1'b1}}};
   localparam logic [W-1:0]  SMIN  = {1'b1, {LW{1'b0}}};

   typedef struct packed {
      logic [W-1:0] x;
      logic [W-1:0] mag;
      logic         above;
   } side1_type;

   typedef struct packed {
      logic [W-1:0] x;
      logic         above;
      logic         yneg;
      logic         ovf;
   } side2_type;

   // ---------------- configuration ----------------
   skc_pkg::reg_index_type csr_index;
   logic                   csr_write;
   logic [LW-1:0]          knee_ff, knee_in;
   logic [LW-1:0]          target_ff, target_in;
   logic [LW-1:0]          max_ff, max_in;
   logic                   bypass_ff, bypass_in;

   assign csr_index  = skc_pkg::reg_index_type'(csr_paddr[skc_pkg::CSR_ADDR_BITS-1:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      knee_in   = knee_ff;
      target_in = target_ff;
      max_in    = max_ff;
      bypass_in = bypass_ff;
      if (csr_write) begin
         case (csr_index)
            skc_pkg::REG_KNEE:   knee_in   = csr_pwdata[LW-1:0];
            skc_pkg::REG_TARGET: target_in = csr_pwdata[LW-1:0];
            skc_pkg::REG_MAX:    max_in    = csr_pwdata[LW-1:0];
            skc_pkg::REG_BYPASS: bypass_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         knee_ff   <= '0;
         target_ff <= UNITY;
         max_ff    <= UNITY;
         bypass_ff <= 1'b0;
      end else begin
         knee_ff   <= knee_in;
         target_ff <= target_in;
         max_ff    <= max_in;
         bypass_ff <= bypass_in;
      end
   end

   always_comb begin
      case (csr_index)
         skc_pkg::REG_KNEE:   csr_prdata = DW'(knee_ff);
         skc_pkg::REG_TARGET: csr_prdata = DW'(target_ff);
         skc_pkg::REG_MAX:    csr_prdata = DW'(max_ff);
         skc_pkg::REG_BYPASS: csr_prdata = DW'(bypass_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // Spans derived from the levels, registered once more behind the level registers.
   logic [LW-1:0] tk_abs_ff, tk_abs_in;
   logic [LW-1:0] mk_abs_ff, mk_abs_in;
   logic          qneg_ff, qneg_in;

   assign tk_abs_in = (target_ff >= knee_ff) ? (target_ff - knee_ff) : (knee_ff - target_ff);
   assign mk_abs_in = (max_ff >= knee_ff) ? (max_ff - knee_ff) : (knee_ff - max_ff);
   assign qneg_in   = (target_ff < knee_ff) ^ (max_ff < knee_ff);

   always_ff @(posedge clock) begin
      tk_abs_ff <= tk_abs_in;
      mk_abs_ff <= mk_abs_in;
      qneg_ff   <= qneg_in;
   end

   // ---------------- pipeline ----------------
   logic advance;
   logic skid_valid_ff;

   assign advance   = ~skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // stage 1: capture
   logic         p1_valid_ff;
   logic [W-1:0] p1_x_ff;

   // stage 2: magnitude and distance above the knee
   logic         p2_valid_ff;
   logic [W-1:0] p2_x_ff, p2_mag_ff, p2_diff_ff;
   logic         p2_above_ff;
   logic [W-1:0] p2_mag_in, p2_diff_in;
   logic         p2_above_in;

   assign p2_mag_in   = p1_x_ff[W-1] ? W'(~p1_x_ff + 1'b1) : p1_x_ff;
   assign p2_above_in = p2_mag_in > {1'b0, knee_ff};
   assign p2_diff_in  = p2_mag_in - {1'b0, knee_ff};

   // stage 3: numerator of the knee mapping
   logic          p3_valid_ff;
   logic [NW-1:0] p3_num_ff, p3_num_in;
   side1_type     p3_side_ff;

   assign p3_num_in = p2_diff_ff * tk_abs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
      end else if (advance) begin
         p1_valid_ff <= req_valid;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_x_ff          <= req_sample_in;
         p2_x_ff          <= p1_x_ff;
         p2_mag_ff        <= p2_mag_in;
         p2_diff_ff       <= p2_diff_in;
         p2_above_ff      <= p2_above_in;
         p3_num_ff        <= p3_num_in;
         p3_side_ff.x     <= p2_x_ff;
         p3_side_ff.mag   <= p2_mag_ff;
         p3_side_ff.above <= p2_above_ff;
      end
   end

   // first division: |num| / |max - knee|
   logic          d1_valid;
   logic [NW-1:0] d1_quot;
   side1_type     d1_side;

   skc_div_chain #(
      .DIV_BITS  (LW),
      .ACC_BITS  (NW),
      .SIDE_BITS ($bits(side1_type))
   ) u_div_knee (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .divisor   (mk_abs_ff),
      .in_valid  (p3_valid_ff),
      .in_rem    ('0),
      .in_acc    (p3_num_ff),
      .in_side   (p3_side_ff),
      .out_valid (d1_valid),
      .out_quot  (d1_quot),
      .out_side  (d1_side)
   );

   // stage 4: compressed level c, signed
   logic          p4_valid_ff;
   logic [NW:0]   p4_c_ff, p4_c_in;
   logic [W-1:0]  p4_x_ff;
   logic          p4_above_ff;
   logic [NW:0]   knee_ext, quot_ext;

   assign knee_ext = (NW+1)'(knee_ff);
   assign quot_ext = {1'b0, d1_quot};
   assign p4_c_in  = !d1_side.above ? (NW+1)'(d1_side.mag) :
                     qneg_ff ? (knee_ext - quot_ext) : (knee_ext + quot_ext);

   // stage 5: magnitude of the signed level and sign of the result
   logic          p5_valid_ff;
   logic [NW-1:0] p5_cmag_ff, p5_cmag_in;
   logic [NW:0]   c_neg;
   logic [W-1:0]  p5_x_ff;
   logic          p5_above_ff, p5_yneg_ff, p5_yneg_in;

   assign c_neg      = (NW+1)'(~p4_c_ff + 1'b1);
   assign p5_cmag_in = p4_c_ff[NW] ? c_neg[NW-1:0] : p4_c_ff[NW-1:0];
   assign p5_yneg_in = p4_x_ff[W-1] ^ p4_c_ff[NW];

   // stage 6: makeup gain numerator
   logic          p6_valid_ff;
   logic [PW-1:0] p6_prod_ff, p6_prod_in;
   logic [W-1:0]  p6_x_ff;
   logic          p6_above_ff, p6_yneg_ff;

   assign p6_prod_in = p5_cmag_ff * max_ff;

   // stage 7: overflow check, only SAMPLE_BITS quotient bits are kept
   logic          p7_valid_ff;
   logic [LW-1:0] p7_rem_ff;
   logic [W-1:0]  p7_acc_ff;
   side2_type     p7_side_ff;
   logic          p7_ovf_in;

   assign p7_ovf_in = p6_prod_ff[PW-1:W] >= (PW-W)'(target_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_valid_ff <= 1'b0;
         p5_valid_ff <= 1'b0;
         p6_valid_ff <= 1'b0;
         p7_valid_ff <= 1'b0;
      end else if (advance) begin
         p4_valid_ff <= d1_valid;
         p5_valid_ff <= p4_valid_ff;
         p6_valid_ff <= p5_valid_ff;
         p7_valid_ff <= p6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p4_c_ff          <= p4_c_in;
         p4_x_ff          <= d1_side.x;
         p4_above_ff      <= d1_side.above;
         p5_cmag_ff       <= p5_cmag_in;
         p5_x_ff          <= p4_x_ff;
         p5_above_ff      <= p4_above_ff;
         p5_yneg_ff       <= p5_yneg_in;
         p6_prod_ff       <= p6_prod_in;
         p6_x_ff          <= p5_x_ff;
         p6_above_ff      <= p5_above_ff;
         p6_yneg_ff       <= p5_yneg_ff;
         p7_rem_ff        <= p6_prod_ff[W+LW-1:W];
         p7_acc_ff        <= p6_prod_ff[W-1:0];
         p7_side_ff.x     <= p6_x_ff;
         p7_side_ff.above <= p6_above_ff;
         p7_side_ff.yneg  <= p6_yneg_ff;
         p7_side_ff.ovf   <= p7_ovf_in;
      end
   end

   // second division: |s| * max / target
   logic         d2_valid;
   logic [W-1:0] d2_quot;
   side2_type    d2_side;

   skc_div_chain #(
      .DIV_BITS  (LW),
      .ACC_BITS  (W),
      .SIDE_BITS ($bits(side2_type))
   ) u_div_gain (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .divisor   (target_ff),
      .in_valid  (p7_valid_ff),
      .in_rem    (p7_rem_ff),
      .in_acc    (p7_acc_ff),
      .in_side   (p7_side_ff),
      .out_valid (d2_valid),
      .out_quot  (d2_quot),
      .out_side  (d2_side)
   );

   // final saturation
   logic [W-1:0] fin_sample;
   logic         fin_clip;
   logic [W-1:0] quot_neg;

   assign quot_neg = W'(~d2_quot + 1'b1);

   always_comb begin
      fin_sample = d2_quot;
      fin_clip   = 1'b0;
      if (bypass_ff) begin
         fin_sample = d2_side.x;
      end else if ((d2_side.above && (knee_ff == max_ff)) || (target_ff == '0)) begin
         // zero divisor: saturate by the input sign
         fin_sample = d2_side.x[W-1] ? SMIN : SMAX;
         fin_clip   = 1'b1;
      end else if (d2_side.ovf) begin
         fin_sample = d2_side.yneg ? SMIN : SMAX;
         fin_clip   = 1'b1;
      end else if (d2_side.yneg) begin
         if (d2_quot > SMIN) begin
            fin_sample = SMIN;
            fin_clip   = 1'b1;
         end else begin
            fin_sample = quot_neg;
         end
      end else if (d2_quot[W-1]) begin
         fin_sample = SMAX;
         fin_clip   = 1'b1;
      end
   end

   // ---------------- output register and skid ----------------
   logic         take, push;
   logic         out_valid_ff, out_valid_in;
   logic [W-1:0] out_sample_ff, out_sample_in;
   logic         out_clipped_ff, out_clipped_in;
   logic         skid_valid_in;
   logic [W-1:0] skid_sample_ff, skid_sample_in;
   logic         skid_clipped_ff, skid_clipped_in;

   assign take = out_valid_ff & ~rsp_stall;
   assign push = advance & d2_valid;

   always_comb begin
      out_valid_in    = out_valid_ff;
      out_sample_in   = out_sample_ff;
      out_clipped_in  = out_clipped_ff;
      skid_valid_in   = skid_valid_ff;
      skid_sample_in  = skid_sample_ff;
      skid_clipped_in = skid_clipped_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_sample_in  = skid_sample_ff;
            out_clipped_in = skid_clipped_ff;
            skid_valid_in  = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || take) begin
            out_valid_in   = 1'b1;
            out_sample_in  = fin_sample;
            out_clipped_in = fin_clip;
         end else begin
            skid_valid_in   = 1'b1;
            skid_sample_in  = fin_sample;
            skid_clipped_in = fin_clip;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_sample_ff   <= out_sample_in;
      out_clipped_ff  <= out_clipped_in;
      skid_sample_ff  <= skid_sample_in;
      skid_clipped_ff <= skid_clipped_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_sample_out = out_sample_ff;
   assign rsp_clipped    = out_clipped_ff;

   // ---------------- assertions ----------------
   `ASSERT_IMPLIES(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `ASSERT_IMPLIES(a_skid_fill_on_hold, clock, reset, $rose(skid_valid_ff), $past(out_valid_ff && rsp_stall))
   `ASSERT_NEXT(a_front_holds, clock, reset, skid_valid_ff, $stable(p1_valid_ff))
   `ASSERT_IMPLIES(a_clip_saturates, clock, reset, out_valid_ff && out_clipped_ff, (out_sample_ff == SMAX) || (out_sample_ff == SMIN))

endmodule

[sim/static_knee_compressor_tb.sv]
`timescale 1ns / 100ps

module static_knee_compressor_tb;

   localparam int     SB             = skc_pkg::SAMPLE_BITS_DEF;
   localparam int     FB             = skc_pkg::FRAC_BITS_DEF;
   localparam int     AB             = skc_pkg::CSR_ADDR_BITS;
   localparam int     DB             = skc_pkg::CSR_DATA_BITS;
   localparam longint LEVEL_TOP      = (longint'(1) << (SB - 1)) - 1;
   localparam longint LEVEL_BOTTOM   = -LEVEL_TOP - 1;
   localparam int     LATENCY        = 3 * SB + 7;
   localparam int     WATCHDOG_LIMIT = 2000;
   localparam int     HOLD_CYCLES    = 400;
   localparam int     PHASE_ITEMS    = 90;
   localparam int     NUM_PHASES     = 8;

   typedef logic [SB-2:0]        level_type;
   typedef logic signed [SB-1:0] sample_type;

   typedef struct packed {
      sample_type sample_in;
      sample_type sample_out;
      logic       clipped;
   } gain_result_type;

   typedef struct packed {
      level_type  knee;
      level_type  target;
      level_type  peak;
      logic       bypass;
      sample_type sample_in;
      logic       typed;
      sample_type sample_out;
      logic       clipped;
   } directed_row_type;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   sample_type      req_sample_in;
   logic            rsp_valid;
   logic            rsp_stall;
   sample_type      rsp_sample_out;
   logic            rsp_clipped;
   logic            csr_psel;
   logic            csr_penable;
   logic            csr_pwrite;
   logic [AB-1:0]   csr_paddr;
   logic [DB-1:0]   csr_pwdata;
   logic [DB-1:0]   csr_prdata;
   logic            csr_pready;

   // register mirror used by the gain predictor
   level_type cfg_knee;
   level_type cfg_target;
   level_type cfg_peak;
   logic      cfg_bypass;

   gain_result_type  expected_q[$];
   directed_row_type directed_q[$];

   int         error_count;
   int         quiet_cycles;
   int         gap_pct;
   int         stall_pct;
   int         hold_requests;
   int         hold_served;
   int         hold_left;
   logic       typed_valid;
   sample_type typed_out;
   logic       typed_clip;

   static_knee_compressor #(
      .SAMPLE_BITS(SB),
      .FRAC_BITS(FB)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sample_in(req_sample_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_sample_out(rsp_sample_out),
      .rsp_clipped(rsp_clipped),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   task automatic report_error(input string what);
      $display("%0t ERROR %s", $time, what);
      error_count++;
   endtask

   function automatic gain_result_type compress_sample(input sample_type x_in);
      gain_result_type r;
      longint x, mag, k, t, m, den, c, s, y, sat;
      logic neg;
      x   = x_in;
      neg = (x < 0);
      k   = cfg_knee;
      t   = cfg_target;
      m   = cfg_peak;
      sat = neg ? LEVEL_BOTTOM : LEVEL_TOP;
      r.sample_in = x_in;
      r.clipped   = 1'b0;
      if (cfg_bypass) begin
         r.sample_out = x_in;
         return r;
      end
      mag = neg ? -x : x;
      if (mag > k) begin
         den = m - k;
         // flat knee span: nothing to divide by, saturate by sign
         if (den == 0) begin
            r.sample_out = sample_type'(sat);
            r.clipped    = 1'b1;
            return r;
         end
         c = ((mag - k) * (t - k)) / den + k;
      end else begin
         c = mag;
      end
      s = neg ? -c : c;
      if (t == 0) begin
         r.sample_out = sample_type'(sat);
         r.clipped    = 1'b1;
         return r;
      end
      y = (s * m) / t;
      if (y > LEVEL_TOP) begin
         r.sample_out = sample_type'(LEVEL_TOP);
         r.clipped    = 1'b1;
      end else if (y < LEVEL_BOTTOM) begin
         r.sample_out = sample_type'(LEVEL_BOTTOM);
         r.clipped    = 1'b1;
      end else begin
         r.sample_out = sample_type'(y);
      end
      return r;
   endfunction

   function automatic level_type pick_level();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return level_type'(LEVEL_TOP);
         2: return level_type'(1 << FB);
         default: return level_type'($urandom_range(0, 32767));
      endcase
   endfunction

   function automatic sample_type pick_sample();
      int v;
      int kind;
      kind = $urandom_range(0, 5);
      case (kind)
         0, 1: v = $urandom;
         2: v = int'(cfg_knee) + int'($urandom_range(0, 2)) - 1;
         3: v = int'(cfg_peak) - int'($urandom_range(0, 3));
         4: begin
            case ($urandom_range(0, 3))
               0: v = -32768;
               1: v = 32767;
               2: v = 0;
               default: v = -1;
            endcase
         end
         default: v = $urandom_range(0, 600);
      endcase
      if (kind >= 2 && kind != 4 && $urandom_range(0, 1) == 1)
         v = -v;
      return sample_type'(v);
   endfunction

   task automatic csr_access(input logic wr, input skc_pkg::reg_index_type idx,
                             input logic [DB-1:0] wdata,
                             output logic [DB-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic write_setting(input skc_pkg::reg_index_type idx,
                                input logic [DB-1:0] value);
      logic [DB-1:0] rdata;
      csr_access(1'b1, idx, value, rdata);
      case (idx)
         skc_pkg::REG_KNEE:   cfg_knee   = value[SB-2:0];
         skc_pkg::REG_TARGET: cfg_target = value[SB-2:0];
         skc_pkg::REG_MAX:    cfg_peak   = value[SB-2:0];
         skc_pkg::REG_BYPASS: cfg_bypass = value[0];
         default: ;
      endcase
      csr_access(1'b0, idx, '0, rdata);
      if (rdata !== value)
         report_error($sformatf("register %s read back %0h, wrote %0h", idx.name(), rdata,
                                value));
   endtask

   task automatic wait_drained();
      while (expected_q.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic apply_settings(input level_type knee, input level_type target,
                                 input level_type peak, input logic bypass);
      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();
      write_setting(skc_pkg::REG_KNEE, DB'(knee));
      write_setting(skc_pkg::REG_TARGET, DB'(target));
      write_setting(skc_pkg::REG_MAX, DB'(peak));
      write_setting(skc_pkg::REG_BYPASS, DB'(bypass));
   endtask

   task automatic send_sample(input sample_type x, input logic typed, input sample_type out,
                              input logic clip);
      while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_sample_in <= x;
      typed_valid   <= typed;
      typed_out     <= out;
      typed_clip    <= clip;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic add_row(input int knee, input int target, input int peak, input logic bypass,
                          input int x, input logic typed, input int out, input logic clip);
      directed_row_type row;
      row.knee       = level_type'(knee);
      row.target     = level_type'(target);
      row.peak       = level_type'(peak);
      row.bypass     = bypass;
      row.sample_in  = sample_type'(x);
      row.typed      = typed;
      row.sample_out = sample_type'(out);
      row.clipped    = clip;
      directed_q.push_back(row);
   endtask

   // expectations are queued at the edge where the sample is taken
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         if (typed_valid)
            expected_q.push_back({req_sample_in, typed_out, typed_clip});
         else
            expected_q.push_back(compress_sample(req_sample_in));
      end
   end

   always @(posedge clock) begin
      gain_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            report_error($sformatf("unexpected result %0d clipped %0b", rsp_sample_out,
                                   rsp_clipped));
         end else begin
            want = expected_q.pop_front();
            if (rsp_sample_out !== want.sample_out)
               report_error($sformatf("sample_out for input %0d: got %0d, want %0d",
                                      want.sample_in, rsp_sample_out, want.sample_out));
            if (rsp_clipped !== want.clipped)
               report_error($sformatf("clipped for input %0d: got %0b, want %0b",
                                      want.sample_in, rsp_clipped, want.clipped));
         end
      end
   end

   // receiver: random stall, or a long hold-off when requested
   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served++;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      directed_row_type row;
      level_type        k, t, p;
      logic             b;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_sample_in = '0;
      rsp_stall     = 1'b0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      typed_valid   = 1'b0;
      typed_out     = '0;
      typed_clip    = 1'b0;
      error_count   = 0;
      quiet_cycles  = 0;
      gap_pct       = 0;
      stall_pct     = 0;
      hold_requests = 0;
      hold_served   = 0;
      hold_left     = 0;
      cfg_knee      = '0;
      cfg_target    = level_type'(1 << FB);
      cfg_peak      = level_type'(1 << FB);
      cfg_bypass    = 1'b0;

      // reset values: knee 0 and unity gain give identity
      add_row(0, 16384, 16384, 0, 0, 1, 0, 0);
      add_row(0, 16384, 16384, 0, 32767, 1, 32767, 0);
      add_row(0, 16384, 16384, 0, -32768, 1, -32768, 0);
      add_row(0, 16384, 16384, 0, 1, 1, 1, 0);
      add_row(0, 16384, 16384, 0, -1, 1, -1, 0);
      // bypass
      add_row(0, 16384, 16384, 1, -32768, 1, -32768, 0);
      add_row(0, 16384, 16384, 1, 32767, 1, 32767, 0);
      add_row(0, 16384, 16384, 1, 21845, 1, 21845, 0);
      add_row(0, 16384, 16384, 1, -21846, 1, -21846, 0);
      // flat knee span
      add_row(1000, 500, 1000, 0, 2000, 1, 32767, 1);
      add_row(1000, 500, 1000, 0, -2000, 1, -32768, 1);
      add_row(1000, 500, 1000, 0, 1000, 0, 0, 0);
      add_row(1000, 500, 1000, 0, -700, 0, 0, 0);
      // zero target saturates by sign
      add_row(0, 0, 16384, 0, 5, 1, 32767, 1);
      add_row(0, 0, 16384, 0, -5, 1, -32768, 1);
      add_row(0, 0, 16384, 0, 0, 1, 32767, 1);
      // makeup gain overflow
      add_row(8192, 100, 32767, 0, 4000, 1, 32767, 1);
      add_row(8192, 100, 32767, 0, -4000, 1, -32768, 1);
      add_row(8192, 100, 32767, 0, 30000, 0, 0, 0);
      // max below knee inverts the mapping
      add_row(20000, 10000, 5000, 0, 30000, 0, 0, 0);
      add_row(20000, 10000, 5000, 0, -30000, 0, 0, 0);
      add_row(20000, 10000, 5000, 0, 20000, 0, 0, 0);
      // all levels at the top
      add_row(32767, 32767, 32767, 0, -32768, 1, -32768, 1);
      add_row(32767, 32767, 32767, 0, 32767, 1, 32767, 0);
      // ordinary compression
      add_row(8192, 12000, 24000, 0, 16000, 0, 0, 0);
      add_row(8192, 12000, 24000, 0, -16000, 0, 0, 0);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_q[i]) begin
         row = directed_q[i];
         if (row.knee != cfg_knee || row.target != cfg_target || row.peak != cfg_peak ||
             row.bypass != cfg_bypass)
            apply_settings(row.knee, row.target, row.peak, row.bypass);
         send_sample(row.sample_in, row.typed, row.sample_out, row.clipped);
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph == 0) begin
            k = '0;
            t = level_type'(LEVEL_TOP);
            p = level_type'(LEVEL_TOP);
         end else if ($urandom_range(0, 2) != 0) begin
            k = level_type'($urandom_range(0, 24000));
            p = level_type'($urandom_range(int'(k) + 1, 32767));
            t = level_type'($urandom_range(1, int'(p)));
         end else begin
            k = pick_level();
            t = pick_level();
            p = pick_level();
         end
         b = (ph == NUM_PHASES - 1) || ($urandom_range(0, 7) == 0);
         apply_settings(k, t, p, b);

         case (ph % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 75; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 75; end
            default: begin gap_pct = 21; stall_pct = 21; end
         endcase

         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // long receiver hold-off so the pipeline fills and backs up
            if (ph == 4 && i == 10)
               hold_requests++;
            send_sample(pick_sample(), 1'b0, '0, 1'b0);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

[static_knee_compressor.f]
+incdir+rtl
rtl/skc_pkg.sv
rtl/skc_div_cell.sv
rtl/skc_div_chain.sv
rtl/static_knee_compressor.sv
sim/static_knee_compressor_tb.sv
